FILE: design/median_corrected_cycle_measure_top_macros.svh
// Assertion macros shared by the checker of the median cycle measure block.
`ifndef MEDIAN_CORRECTED_CYCLE_MEASURE_TOP_MACROS_SVH
`define MEDIAN_CORRECTED_CYCLE_MEASURE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MCCM_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MCCM_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: design/mccm_pkg.sv
// Shared constants, controller states and command/status types of the median cycle measure block.
package mccm_pkg;

	localparam int STAMP_W      = 64;
	localparam int RUN_W        = 7;
	localparam int MIN_RUNS     = 3;
	localparam int DEF_MAX_RUNS = 64;
	localparam logic [RUN_W-1:0] RUN_RESET = RUN_W'(3);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PREP   = 7'b0000010,
		ST_LOOK   = 7'b0000100,
		ST_CMP    = 7'b0001000,
		ST_PLACE  = 7'b0010000,
		ST_MEDREQ = 7'b0100000,
		ST_MEDGET = 7'b1000000
	} state_t;

	typedef struct packed {
		logic accept;
		logic correct;
		logic rd_prev;
		logic rd_prev2;
		logic shift;
		logic place;
		logic rd_med;
		logic take_med;
	} cmd_t;

	typedef struct packed {
		logic pos_zero;
		logic pos_one;
		logic prev_gt;
		logic phase_end;
		logic measuring;
		logic out_busy;
	} status_t;

endpackage

FILE: design/mccm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mccm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/mccm_ctrl.sv
// Controller state machine: input handshake and sequencing of the sorted insert and median read.
module mccm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output mccm_pkg::cmd_t   cmd,
	input  mccm_pkg::status_t status
);

	import mccm_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.correct = 1'b1;
				state_d     = ST_LOOK;
			end
			ST_LOOK: begin
				if (status.pos_zero) begin
					state_d = ST_PLACE;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = ST_CMP;
				end
			end
			ST_CMP: begin
				// shift the larger neighbor up and fetch the next one below
				if (status.prev_gt) begin
					cmd.shift = 1'b1;
					if (status.pos_one) begin
						state_d = ST_PLACE;
					end else begin
						cmd.rd_prev2 = 1'b1;
					end
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				state_d   = status.phase_end ? ST_MEDREQ : ST_IDLE;
			end
			ST_MEDREQ: begin
				// in the measured phase, hold until the previous result has left the output register
				if (!(status.measuring && status.out_busy)) begin
					cmd.rd_med = 1'b1;
					state_d    = ST_MEDGET;
				end
			end
			ST_MEDGET: begin
				cmd.take_med = 1'b1;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: design/mccm_dp.sv
// Datapath: run count register, duration and correction, sorted stores, overhead and output registers.
module mccm_dp #(
	parameter int MAX_RUNS = mccm_pkg::DEF_MAX_RUNS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [mccm_pkg::RUN_W-1:0]    cfg_data,
	input  logic [mccm_pkg::STAMP_W-1:0]  start_stamp,
	input  logic [mccm_pkg::STAMP_W-1:0]  end_stamp,
	input  mccm_pkg::cmd_t                cmd,
	output mccm_pkg::status_t             status,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [mccm_pkg::STAMP_W-1:0]  median_cycles,
	output logic [mccm_pkg::STAMP_W-1:0]  overhead_cycles
);

	import mccm_pkg::*;

	localparam int IDX_W = $clog2(MAX_RUNS);
	localparam int N_W   = $clog2(MAX_RUNS + 1);

	logic [RUN_W-1:0]   run_count_q;
	logic [N_W-1:0]     n_q;
	logic [N_W-1:0]     n_eff;
	logic [STAMP_W-1:0] val_q;
	logic [IDX_W-1:0]   pos_q;
	logic [IDX_W-1:0]   cnt_q;
	logic               phase_q;
	logic [STAMP_W-1:0] overhead_q;
	logic               out_valid_q;
	logic [STAMP_W-1:0] median_q;
	logic [STAMP_W-1:0] oh_out_q;

	logic [STAMP_W:0]   corr_diff;
	logic [N_W-1:0]     cnt_inc;
	logic [IDX_W-1:0]   med_idx;
	logic               ram_we;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_waddr;
	logic [STAMP_W-1:0] ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [STAMP_W-1:0] cal_rdata;
	logic [STAMP_W-1:0] meas_rdata;
	logic [STAMP_W-1:0] rd_data;

	// raise small counts to the floor and saturate at the store depth
	always_comb begin
		if (32'(run_count_q) > MAX_RUNS) begin
			n_eff = N_W'(MAX_RUNS);
		end else if (32'(run_count_q) < MIN_RUNS) begin
			n_eff = N_W'(MIN_RUNS);
		end else begin
			n_eff = N_W'(run_count_q);
		end
	end

	assign corr_diff = {1'b0, val_q} - {1'b0, overhead_q};
	assign cnt_inc   = N_W'(cnt_q) + N_W'(1);
	assign med_idx   = IDX_W'(n_q >> 1);
	assign rd_data   = phase_q ? meas_rdata : cal_rdata;

	assign ram_we    = cmd.shift | cmd.place;
	assign ram_waddr = pos_q;
	assign ram_wdata = cmd.shift ? rd_data : val_q;
	assign ram_re    = cmd.rd_prev | cmd.rd_prev2 | cmd.rd_med;

	always_comb begin
		priority if (cmd.rd_med) begin
			ram_raddr = med_idx;
		end else if (cmd.rd_prev) begin
			ram_raddr = pos_q - IDX_W'(1);
		end else begin
			ram_raddr = pos_q - IDX_W'(2);
		end
	end

	mccm_ram #(
		.WIDTH (STAMP_W),
		.DEPTH (MAX_RUNS)
	) u_cal_ram (
		.clk   (clk),
		.we    (ram_we & ~phase_q),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re & ~phase_q),
		.raddr (ram_raddr),
		.rdata (cal_rdata)
	);

	mccm_ram #(
		.WIDTH (STAMP_W),
		.DEPTH (MAX_RUNS)
	) u_meas_ram (
		.clk   (clk),
		.we    (ram_we & phase_q),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re & phase_q),
		.raddr (ram_raddr),
		.rdata (meas_rdata)
	);

	always_comb begin
		status           = '0;
		status.pos_zero  = (pos_q == '0);
		status.pos_one   = (pos_q == IDX_W'(1));
		status.prev_gt   = (rd_data > val_q);
		status.phase_end = (cnt_inc >= n_q);
		status.measuring = phase_q;
		status.out_busy  = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= RUN_RESET;
			cnt_q       <= '0;
			phase_q     <= 1'b0;
			overhead_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				run_count_q <= cfg_data;
			end
			if (cmd.place) begin
				cnt_q <= status.phase_end ? '0 : IDX_W'(cnt_inc);
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.take_med) begin
				if (phase_q) begin
					out_valid_q <= 1'b1;
					phase_q     <= 1'b0;
				end else begin
					overhead_q <= rd_data;
					phase_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q <= end_stamp - start_stamp;
			n_q   <= n_eff;
			pos_q <= cnt_q;
		end
		// clamp the corrected duration at zero
		if (cmd.correct && phase_q) begin
			val_q <= corr_diff[STAMP_W] ? '0 : corr_diff[STAMP_W-1:0];
		end
		if (cmd.shift) begin
			pos_q <= pos_q - IDX_W'(1);
		end
		if (cmd.take_med && phase_q) begin
			median_q <= rd_data;
			oh_out_q <= overhead_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign median_cycles   = median_q;
	assign overhead_cycles = oh_out_q;

endmodule

FILE: design/median_corrected_cycle_measure_top.sv
// Top level of the median cycle measure block: controller, datapath and configuration port.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------
//  in       | in_valid / in_stall   | start_stamp, end_stamp
//  out      | out_valid / out_stall | median_cycles, overhead_cycles
//  cfg      | cfg_valid / cfg_ready | cfg_data (run count)
//
// An item goes through accept, correction, look-up, k loop steps and placement, k being the
// number of stored entries it moves past in the insertion loop (up to MAX_RUNS - 1), one RAM
// read and one RAM write per step. The last item of a phase adds the median read request and
// fetch, and in the measured phase waits as well while the previous result is still stalled.
// Reset clears the phase, the count, the overhead and the output valid; the stores need no
// clearing. in_stall is high whenever an item is in progress; cfg_ready is always high.
module median_corrected_cycle_measure_top #(
	parameter int MAX_RUNS = mccm_pkg::DEF_MAX_RUNS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mccm_pkg::RUN_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [mccm_pkg::STAMP_W-1:0] start_stamp,
	input  logic [mccm_pkg::STAMP_W-1:0] end_stamp,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mccm_pkg::STAMP_W-1:0] median_cycles,
	output logic [mccm_pkg::STAMP_W-1:0] overhead_cycles
);

	import mccm_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	mccm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status)
	);

	mccm_dp #(
		.MAX_RUNS (MAX_RUNS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.start_stamp     (start_stamp),
		.end_stamp       (end_stamp),
		.cmd             (cmd),
		.status          (status),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.median_cycles   (median_cycles),
		.overhead_cycles (overhead_cycles)
	);

endmodule

FILE: design/mccm_checker.sv
// Port-level checker for the median cycle measure block, bound to its top level.
`include "median_corrected_cycle_measure_top_macros.svh"

module mccm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] median_cycles,
	input logic [63:0] overhead_cycles
);

	// an accepted transaction is followed by a stalled input in the next cycle
	`MCCM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept not followed by stall")

	// a result appears only at the end of an item's work
	`MCCM_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall), "result without work")

	`MCCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(median_cycles) && $stable(overhead_cycles), "stalled result changed")

	`MCCM_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind median_corrected_cycle_measure_top mccm_checker u_mccm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cfg_valid       (cfg_valid),
	.cfg_ready       (cfg_ready),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.median_cycles   (median_cycles),
	.overhead_cycles (overhead_cycles)
);
